// ===== src/cpc_pkg.sv =====
// Shared types, constants and the arctangent table of the coordinate converter.
package cpc_pkg;

    localparam int unsigned ITERATIONS   = 16;
    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned FRAC_BITS    = 14;
    localparam int unsigned XW           = 34;
    localparam int unsigned ZW           = 33;

    localparam logic [31:0] INV_GAIN     = 32'h9B74_EDA8;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

    localparam logic OP_TO_POLAR = 1'b0;
    localparam logic OP_TO_CART  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
        logic [15:0]        radius_in;
        logic [15:0]        angle_in;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic [15:0]        radius_out;
        logic [15:0]        angle_out;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic                 operation;
        logic                 origin;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cell_word_t;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

// ===== src/cpc_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
interface cpc_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/cartesian_polar_converter_top.sv =====
// Top level of the pipelined CORDIC cartesian/polar coordinate converter.
//
//   Channel  Role    Word
//   req      sink    operation, x_in, y_in, radius_in, angle_in
//   rsp      source  x_out, y_out, radius_out, angle_out, saturated
//
// A word goes through a registered input stage, one registered rotation cell per
// iteration (at most ATAN_ENTRIES cells) and a registered output stage to rsp.
// One word is taken each cycle unless rsp stalls; the rotation cells set the latency.
// Reset clears every stage's valid flag, so the pipeline starts empty.
// Each stage holds its word while the next one is full and stalled, and empty
// stages are filled at once; ready passes back through the row in the same cycle.
module cartesian_polar_converter_top #(
    parameter int unsigned ITERATIONS = cpc_pkg::ITERATIONS
) (
    input  logic clk,
    input  logic rst_n,
    cpc_if.sink  req,
    cpc_if.source rsp
);

    localparam int unsigned STAGES = (ITERATIONS < cpc_pkg::ATAN_ENTRIES)
                                     ? ITERATIONS : cpc_pkg::ATAN_ENTRIES;

    logic                stage_valid [0:STAGES];
    logic                stage_ready [0:STAGES];
    cpc_pkg::cell_word_t stage_word  [0:STAGES];

    cpc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_word   (req.payload),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_word  (stage_word[0])
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        cpc_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    cpc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[STAGES]),
        .in_ready  (stage_ready[STAGES]),
        .in_word   (stage_word[STAGES]),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_word  (rsp.payload)
    );

endmodule

// ===== src/cpc_prep.sv =====
// Input stage: quadrant folding and gain prescaling ahead of the rotation cells.
module cpc_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpc_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output cpc_pkg::cell_word_t out_word
);

    logic                         valid_reg;
    cpc_pkg::cell_word_t          word_reg;
    cpc_pkg::cell_word_t          word_next;
    logic signed [cpc_pkg::XW-1:0] xv;
    logic signed [cpc_pkg::XW-1:0] yv;
    logic [47:0]                  rprod;
    logic [47:0]                  rsum;
    logic [cpc_pkg::XW-1:0]       rx;
    logic [31:0]                  zu;
    logic [31:0]                  zt;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        xv    = cpc_pkg::XW'(in_word.x_in) <<< cpc_pkg::FRAC_BITS;
        yv    = cpc_pkg::XW'(in_word.y_in) <<< cpc_pkg::FRAC_BITS;
        rprod = 48'(in_word.radius_in) * 48'(cpc_pkg::INV_GAIN);
        rsum  = rprod + 48'(1 << 17);
        rx    = {{(cpc_pkg::XW - 30){1'b0}}, rsum[47:18]};
        zu    = {in_word.angle_in, 16'h0000};
        zt    = zu + cpc_pkg::TURN_QUARTER;

        word_next.operation = in_word.operation;
        word_next.origin    = (in_word.operation == cpc_pkg::OP_TO_POLAR)
                              && (in_word.x_in == 16'sd0) && (in_word.y_in == 16'sd0);
        if (in_word.operation == cpc_pkg::OP_TO_POLAR)
        begin
            if (in_word.x_in[15])
            begin
                word_next.x = -xv;
                word_next.y = -yv;
                word_next.z = cpc_pkg::ZW'(cpc_pkg::TURN_HALF);
            end
            else
            begin
                word_next.x = xv;
                word_next.y = yv;
                word_next.z = '0;
            end
        end
        else
        begin
            word_next.y = '0;
            if (zt[31])
            begin
                word_next.x = -signed'(rx);
                word_next.z = cpc_pkg::ZW'(signed'(zu - cpc_pkg::TURN_HALF));
            end
            else
            begin
                word_next.x = signed'(rx);
                word_next.z = cpc_pkg::ZW'(signed'(zu));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/cpc_cell.sv =====
// One CORDIC micro-rotation stage with its own valid/ready handshake.
module cpc_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpc_pkg::cell_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output cpc_pkg::cell_word_t out_word
);

    localparam logic signed [cpc_pkg::ZW-1:0] ATAN =
        cpc_pkg::ZW'(cpc_pkg::atan_turn(STAGE));

    logic                          valid_reg;
    cpc_pkg::cell_word_t           word_reg;
    cpc_pkg::cell_word_t           word_next;
    logic signed [cpc_pkg::XW-1:0] xs;
    logic signed [cpc_pkg::XW-1:0] ys;
    logic                          neg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        xs  = in_word.x >>> STAGE;
        ys  = in_word.y >>> STAGE;
        neg = (in_word.operation == cpc_pkg::OP_TO_CART) ? in_word.z[cpc_pkg::ZW-1]
                                                         : !in_word.y[cpc_pkg::XW-1];
        word_next = in_word;
        if (neg)
        begin
            word_next.x = in_word.x + ys;
            word_next.y = in_word.y - xs;
            word_next.z = in_word.z + ATAN;
        end
        else
        begin
            word_next.x = in_word.x - ys;
            word_next.y = in_word.y + xs;
            word_next.z = in_word.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/cpc_post.sv =====
// Output stage: gain correction, rounding and saturation into the result word.
module cpc_post (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpc_pkg::cell_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output cpc_pkg::out_word_t  out_word
);

    localparam int unsigned QW = cpc_pkg::XW - cpc_pkg::FRAC_BITS;

    logic                          valid_reg;
    cpc_pkg::out_word_t            word_reg;
    cpc_pkg::out_word_t            word_next;
    logic [cpc_pkg::XW-2:0]        xc;
    logic [64:0]                   mprod;
    logic [64:0]                   msum;
    logic [31:0]                   asum;
    logic signed [cpc_pkg::XW-1:0] xr;
    logic signed [cpc_pkg::XW-1:0] yr;
    logic signed [QW-1:0]          xq;
    logic signed [QW-1:0]          yq;
    logic                          xclip;
    logic                          yclip;

    function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] v);
        logic signed [15:0] res;
        if (v > QW'(32767))
        begin
            res = 16'sh7FFF;
        end
        else if (v < -QW'(32768))
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        xc    = in_word.x[cpc_pkg::XW-1] ? '0 : in_word.x[cpc_pkg::XW-2:0];
        mprod = 65'(xc) * 65'(cpc_pkg::INV_GAIN);
        msum  = mprod + (65'(1) << 45);
        asum  = in_word.z[31:0] + 32'h0000_8000;
        xr    = in_word.x + cpc_pkg::XW'(1 << (cpc_pkg::FRAC_BITS - 1));
        yr    = in_word.y + cpc_pkg::XW'(1 << (cpc_pkg::FRAC_BITS - 1));
        xq    = QW'(xr >>> cpc_pkg::FRAC_BITS);
        yq    = QW'(yr >>> cpc_pkg::FRAC_BITS);
        xclip = (xq > QW'(32767)) || (xq < -QW'(32768));
        yclip = (yq > QW'(32767)) || (yq < -QW'(32768));

        word_next = '0;
        if (in_word.operation == cpc_pkg::OP_TO_CART)
        begin
            word_next.x_out     = sat16(xq);
            word_next.y_out     = sat16(yq);
            word_next.saturated = xclip || yclip;
        end
        else if (!in_word.origin)
        begin
            word_next.radius_out = (|msum[64:62]) ? 16'hFFFF : msum[61:46];
            word_next.angle_out  = asum[31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule
